>>> hw/rtl/dfs_pkg.sv
// Shared types, codes and constants of the depth-first reachability search.
package dfs_pkg;

	localparam int DFS_NODES  = 16;
	localparam int ROW_SLOTS  = 16;
	localparam int IDX_W      = 4;
	localparam int DEPTH_W    = 5;

	localparam logic OP_LOAD   = 1'b0;
	localparam logic OP_SEARCH = 1'b1;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_FINAL
	} dfs_state_t;

	// Outcome of one neighbour scan of the node on top of the stack.
	typedef struct packed {
		logic             empty;
		logic [IDX_W-1:0] next;
	} dfs_scan_t;

	// Per-cycle actions decoded by the sequencer.
	typedef struct packed {
		logic load_row;
		logic init;
		logic pop;
		logic emit_node;
		logic push;
		logic set_found;
		logic emit_final;
	} dfs_ctrl_t;

endpackage

>>> hw/rtl/dfs_stream_if.sv
// Valid/ready channel interfaces for search commands and search results.
interface dfs_cmd_if;
	logic        valid;
	logic        ready;
	logic        operation;
	logic [3:0]  row_index;
	logic [15:0] row_bits;
	logic [3:0]  start_node;
	logic [3:0]  goal_node;

	modport source (output valid, output operation, output row_index, output row_bits,
		output start_node, output goal_node, input ready);
	modport sink (input valid, input operation, input row_index, input row_bits,
		input start_node, input goal_node, output ready);
endinterface

interface dfs_res_if;
	logic       valid;
	logic       ready;
	logic [3:0] node;
	logic       found;
	logic       last;

	modport source (output valid, output node, output found, output last, input ready);
	modport sink (input valid, input node, input found, input last, output ready);
endinterface

>>> hw/rtl/dfs_adj_store.sv
// Adjacency bit matrix: one row written per load, one row read per cycle.
module dfs_adj_store #(
	parameter int NODES = dfs_pkg::DFS_NODES
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        wr_en,
	input  logic [3:0]  wr_row,
	input  logic [15:0] wr_bits,
	input  logic [3:0]  rd_row,
	output logic [15:0] rd_bits
);
	import dfs_pkg::*;

	localparam int LIVE = (NODES >= ROW_SLOTS) ? ROW_SLOTS : NODES;
	localparam logic [ROW_SLOTS-1:0] NODE_MASK =
		ROW_SLOTS'((17'(1) << LIVE) - 17'(1));

	logic [ROW_SLOTS-1:0] rows_q [ROW_SLOTS];
	logic                 row_live;

	// Rows beyond the live node count are never written and stay empty.
	assign row_live = ({1'b0, wr_row} < 5'(LIVE));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < ROW_SLOTS; i++) rows_q[i] <= '0;
		end else if (wr_en && row_live) begin
			rows_q[wr_row] <= wr_bits & NODE_MASK;
		end
	end

	assign rd_bits = rows_q[rd_row];
endmodule

>>> hw/rtl/dfs_scan_unit.sv
// Shared scan unit: lowest unvisited neighbour of one adjacency row.
module dfs_scan_unit (
	input  logic               [15:0] row_bits,
	input  logic               [15:0] visited,
	output dfs_pkg::dfs_scan_t        result
);
	import dfs_pkg::*;

	logic [ROW_SLOTS-1:0] open;

	assign open = row_bits & ~visited;

	always_comb begin
		result.empty = (open == '0);
		result.next  = '0;
		// Walk downwards so that the lowest set bit is the one that remains.
		for (int i = ROW_SLOTS - 1; i >= 0; i--) begin
			if (open[i]) result.next = IDX_W'(i);
		end
	end
endmodule

>>> hw/rtl/dfs_reachability_search.sv
// Top level of the depth-first reachability search over an adjacency matrix.
// The cmd channel takes one transaction per item. A load (operation 0) writes
// one adjacency row and gives no result. A search
// (operation 1) clears the visited marks and walks the graph from start_node,
// always taking the lowest-numbered unvisited neighbour of the node on top of
// the stack. Each newly discovered node leaves on the res channel as one
// transaction, and a final transaction with last set carries found. The walk
// stops as soon as goal_node is discovered; start equal to goal is not found.
// Each discovery or backtrack is one step of the shared scan unit, and cmd.ready
// stays low from the start of a search until it returns to idle; a search that
// hits the goal ends sooner than an exhaustive one.
// Results leave through one output register: a stalled receiver holds the
// walk at its next discovery, while backtracks continue. A command may be
// taken while the final result still waits in that register.
// Reset clears the adjacency matrix (no edges), the visited marks, the stack
// depth and any pending result.
module dfs_reachability_search #(
	parameter int NODES = dfs_pkg::DFS_NODES
) (
	input logic        clk,
	input logic        arst_n,
	dfs_cmd_if.sink    cmd,
	dfs_res_if.source  res
);
	import dfs_pkg::*;

	localparam int LIVE = (NODES >= ROW_SLOTS) ? ROW_SLOTS : NODES;

	dfs_state_t             state_q, state_d;
	dfs_ctrl_t              ctrl;
	dfs_scan_t              scan;

	logic [ROW_SLOTS-1:0]   visited_q;
	logic [IDX_W-1:0]       stack_q [ROW_SLOTS];
	logic [DEPTH_W-1:0]     depth_q;
	logic [IDX_W-1:0]       goal_q;
	logic                   found_q;
	logic                   res_valid_q;
	logic [IDX_W-1:0]       res_node_q;
	logic                   res_found_q;
	logic                   res_last_q;

	logic                   cmd_fire;
	logic                   out_free;
	logic                   start_live;
	logic                   hit_goal;
	logic [IDX_W-1:0]       top_idx;
	logic [IDX_W-1:0]       top_node;
	logic [ROW_SLOTS-1:0]   top_row;

	assign cmd.ready  = (state_q == ST_IDLE);
	assign cmd_fire   = cmd.valid && cmd.ready;
	assign out_free   = !res_valid_q || res.ready;
	assign start_live = ({1'b0, cmd.start_node} < 5'(LIVE));
	assign top_idx    = IDX_W'(depth_q - DEPTH_W'(1));
	assign top_node   = stack_q[top_idx];
	assign hit_goal   = (scan.next == goal_q);

	dfs_adj_store #(.NODES(NODES)) u_adj (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (ctrl.load_row),
		.wr_row  (cmd.row_index),
		.wr_bits (cmd.row_bits),
		.rd_row  (top_node),
		.rd_bits (top_row)
	);

	dfs_scan_unit u_scan (
		.row_bits (top_row),
		.visited  (visited_q),
		.result   (scan)
	);

	// Next state.
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (cmd_fire && cmd.operation == OP_SEARCH) begin
					state_d = start_live ? ST_SCAN : ST_FINAL;
				end
			end
			ST_SCAN: begin
				if (depth_q == '0) begin
					state_d = ST_FINAL;
				end else if (!scan.empty && out_free && hit_goal) begin
					state_d = ST_FINAL;
				end
			end
			ST_FINAL: begin
				if (out_free) state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// Actions of the current cycle.
	always_comb begin
		ctrl = '0;
		case (state_q)
			ST_IDLE: begin
				ctrl.load_row = cmd_fire && cmd.operation == OP_LOAD;
				ctrl.init     = cmd_fire && cmd.operation == OP_SEARCH;
			end
			ST_SCAN: begin
				if (depth_q != '0) begin
					if (scan.empty) begin
						ctrl.pop = 1'b1;
					end else if (out_free) begin
						ctrl.emit_node = 1'b1;
						ctrl.set_found = hit_goal;
						ctrl.push      = !hit_goal;
					end
				end
			end
			ST_FINAL: begin
				ctrl.emit_final = out_free;
			end
			default: ctrl = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			visited_q <= '0;
			depth_q   <= '0;
			found_q   <= 1'b0;
		end else begin
			state_q <= state_d;
			if (ctrl.init) begin
				visited_q <= start_live ? (ROW_SLOTS'(1) << cmd.start_node) : '0;
				depth_q   <= start_live ? DEPTH_W'(1) : '0;
				found_q   <= 1'b0;
			end else begin
				if (ctrl.pop) depth_q <= depth_q - DEPTH_W'(1);
				if (ctrl.push) begin
					visited_q <= visited_q | (ROW_SLOTS'(1) << scan.next);
					depth_q   <= depth_q + DEPTH_W'(1);
				end
				if (ctrl.set_found) found_q <= 1'b1;
				if (ctrl.emit_final) depth_q <= '0;
			end
		end
	end

	// Stack entries and the goal are payload and need no reset.
	always_ff @(posedge clk) begin
		if (ctrl.init) begin
			stack_q[0] <= cmd.start_node;
			goal_q     <= cmd.goal_node;
		end
		if (ctrl.push) stack_q[IDX_W'(depth_q)] <= scan.next;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (ctrl.emit_node || ctrl.emit_final) begin
			res_valid_q <= 1'b1;
		end else if (res.ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.emit_node) begin
			res_node_q  <= scan.next;
			res_found_q <= 1'b0;
			res_last_q  <= 1'b0;
		end else if (ctrl.emit_final) begin
			res_node_q  <= '0;
			res_found_q <= found_q;
			res_last_q  <= 1'b1;
		end
	end

	assign res.valid = res_valid_q;
	assign res.node  = res_node_q;
	assign res.found = res_found_q;
	assign res.last  = res_last_q;

	a_depth_bound: assert property (@(posedge clk) disable iff (!arst_n)
		depth_q <= DEPTH_W'(ROW_SLOTS))
		else $error("node stack depth beyond its capacity");

	a_top_visited: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SCAN && depth_q != '0) |-> visited_q[top_node])
		else $error("node on top of the stack is not marked visited");

	a_final_idle: assert property (@(posedge clk) disable iff (!arst_n)
		ctrl.emit_final |=> (cmd.ready && res.valid && res.last))
		else $error("verdict issued without returning to idle");

	a_no_push_at_goal: assert property (@(posedge clk) disable iff (!arst_n)
		ctrl.set_found |-> !ctrl.push)
		else $error("goal node pushed after it was found");

endmodule

>>> tb/sv/dfs_reachability_search_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench of the depth-first reachability search over random graphs.
module dfs_reachability_search_tb;
	import dfs_pkg::*;

	localparam int CYCLE_LIMIT = 800_000;
	localparam int TAIL_CYCLES = 64;
	localparam int RANDOM_ITEMS = 450;

	typedef struct packed {
		logic [3:0] node;
		logic       found;
		logic       last;
	} walk_result_t;

	logic clk = 1'b0;
	logic arst_n;

	dfs_cmd_if cmd_bus();
	dfs_res_if res_bus();

	dfs_reachability_search dut (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd_bus),
		.res    (res_bus)
	);

	logic [15:0]  adj_rows [16];
	walk_result_t walk_results [$];
	int           fail_count = 0;
	int unsigned  cycle_count = 0;
	int           res_stall = 0;
	bit           no_idle = 1'b0;

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("TB_ERROR");
			$finish;
		end
	end

	function automatic int draw_wait();
		if (no_idle)
			return 0;
		return $urandom_range(0, 11);
	endfunction

	// Walks the mirrored graph and queues every discovery and the verdict.
	function automatic void predict_walk(input logic [3:0] start, input logic [3:0] goal);
		logic [15:0] seen;
		logic [15:0] open;
		logic [3:0]  path [16];
		logic [3:0]  top;
		logic [3:0]  nxt;
		int          depth;
		int          emitted;
		logic        hit;
		seen = 16'h0001 << start;
		path[0] = start;
		depth = 1;
		emitted = 0;
		hit = 1'b0;
		while (depth > 0 && !hit) begin
			top = path[depth-1];
			open = adj_rows[top] & ~seen;
			if (open == 16'h0000) begin
				depth--;
			end else begin
				nxt = 4'd0;
				for (int j = 15; j >= 0; j--)
					if (open[j])
						nxt = j[3:0];
				if (emitted < ROW_SLOTS - 1) begin
					walk_results.push_back('{node: nxt, found: 1'b0, last: 1'b0});
					emitted++;
				end
				if (nxt == goal) begin
					hit = 1'b1;
				end else begin
					seen[nxt] = 1'b1;
					path[depth] = nxt;
					depth++;
				end
			end
		end
		walk_results.push_back('{node: 4'd0, found: hit, last: 1'b1});
	endfunction

	task automatic send_item(input logic op, input logic [3:0] row, input logic [15:0] bits,
			input logic [3:0] start, input logic [3:0] goal);
		int gap;
		gap = draw_wait();
		if (gap > 0) begin
			cmd_bus.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		cmd_bus.valid      <= 1'b1;
		cmd_bus.operation  <= op;
		cmd_bus.row_index  <= row;
		cmd_bus.row_bits   <= bits;
		cmd_bus.start_node <= start;
		cmd_bus.goal_node  <= goal;
		@(posedge clk);
		while (!cmd_bus.ready) @(posedge clk);
		if (op == OP_LOAD)
			adj_rows[row] = bits;
		else
			predict_walk(start, goal);
	endtask

	// The fields a command does not use carry random values.
	task automatic load_row(input logic [3:0] row, input logic [15:0] bits);
		send_item(OP_LOAD, row, bits, 4'($urandom), 4'($urandom));
	endtask

	task automatic search_from(input logic [3:0] start, input logic [3:0] goal);
		send_item(OP_SEARCH, 4'($urandom), 16'($urandom), start, goal);
	endtask

	task automatic wait_for_drain();
		cmd_bus.valid <= 1'b0;
		@(posedge clk);
		while (walk_results.size() != 0) @(posedge clk);
	endtask

	always @(posedge clk) begin : result_check
		walk_result_t want;
		if (!arst_n) begin
			res_bus.ready <= 1'b0;
			res_stall = 0;
		end else begin
			if (res_bus.valid && res_bus.ready) begin
				if (walk_results.size() == 0) begin
					$display("%0t: unexpected result, expected none, actual node %0d found %0d last %0d",
						$time, res_bus.node, res_bus.found, res_bus.last);
					fail_count++;
				end else begin
					want = walk_results.pop_front();
					if (res_bus.node !== want.node) begin
						$display("%0t: node mismatch, expected %0d, actual %0d",
							$time, want.node, res_bus.node);
						fail_count++;
					end
					if (res_bus.found !== want.found) begin
						$display("%0t: found mismatch, expected %0d, actual %0d",
							$time, want.found, res_bus.found);
						fail_count++;
					end
					if (res_bus.last !== want.last) begin
						$display("%0t: last mismatch, expected %0d, actual %0d",
							$time, want.last, res_bus.last);
						fail_count++;
					end
				end
				res_stall = draw_wait();
			end
			if (res_stall > 0) begin
				res_stall--;
				res_bus.ready <= 1'b0;
			end else begin
				res_bus.ready <= 1'b1;
			end
		end
	end

	// With no edges nothing is discovered and the verdict is not found.
	task automatic test_empty_graph();
		search_from(4'd0, 4'd15);
		search_from(4'd15, 4'd0);
		wait_for_drain();
	endtask

	// A full row on an end node reaches every other node, sixteen results at most.
	task automatic test_full_row_sweep();
		load_row(4'd0, 16'hFFFF);
		search_from(4'd0, 4'd0);
		search_from(4'd0, 4'd15);
		search_from(4'd15, 4'd3);
		load_row(4'd15, 16'hFFFF);
		search_from(4'd15, 4'd0);
		search_from(4'd15, 4'd15);
		load_row(4'd15, 16'h0000);
		load_row(4'd0, 16'h0000);
		wait_for_drain();
	endtask

	// Dead ends force a pop before the next branch; a self loop is never rediscovered.
	task automatic test_backtracking();
		load_row(4'd0, 16'h000B);
		load_row(4'd1, 16'h0004);
		load_row(4'd3, 16'h0010);
		search_from(4'd0, 4'd4);
		search_from(4'd0, 4'd0);
		search_from(4'd2, 4'd2);
		search_from(4'd1, 4'd0);
		wait_for_drain();
	endtask

	function automatic logic [15:0] random_row();
		case ($urandom_range(0, 5))
			0: return 16'h0000;
			1: return 16'hFFFF;
			2: return 16'($urandom & $urandom & $urandom);
			3: return 16'($urandom & $urandom);
			4: return 16'($urandom | $urandom);
			default: return 16'($urandom);
		endcase
	endfunction

	task automatic test_random_walks(input int n_items);
		logic [3:0] start;
		logic [3:0] goal;
		for (int k = 0; k < n_items; k++) begin
			if (k % 60 == 59)
				no_idle = ~no_idle;
			if (k % 150 == 149)
				wait_for_drain();
			if ($urandom_range(0, 9) < 5) begin
				load_row(4'($urandom), random_row());
			end else begin
				start = 4'($urandom);
				goal = ($urandom_range(0, 7) == 0) ? start : 4'($urandom);
				search_from(start, goal);
			end
		end
		no_idle = 1'b0;
		wait_for_drain();
	endtask

	initial begin
		for (int r = 0; r < 16; r++)
			adj_rows[r] = 16'h0000;
		arst_n             <= 1'b0;
		cmd_bus.valid      <= 1'b0;
		cmd_bus.operation  <= OP_LOAD;
		cmd_bus.row_index  <= 4'd0;
		cmd_bus.row_bits   <= 16'h0000;
		cmd_bus.start_node <= 4'd0;
		cmd_bus.goal_node  <= 4'd0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_empty_graph();
		test_full_row_sweep();
		test_backtracking();
		test_random_walks(RANDOM_ITEMS);

		// A trailing search may still be busy; give it time to show any stray transaction.
		repeat (TAIL_CYCLES) @(posedge clk);
		if (fail_count == 0 && walk_results.size() == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule

>>> filelist.f
hw/rtl/dfs_pkg.sv
hw/rtl/dfs_stream_if.sv
hw/rtl/dfs_adj_store.sv
hw/rtl/dfs_scan_unit.sv
hw/rtl/dfs_reachability_search.sv
tb/sv/dfs_reachability_search_tb.sv
